>>> hw/rtl/bsm_pkg.sv
package bsm_pkg;

  // Default coordinate width of the edge registers, in bits
  localparam int COORD_BITS_DEF = 12;

  // Fixed register widths for the sprite size
  localparam int SPRW_BITS = 9;
  localparam int SPRH_BITS = 10;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_LEFT   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_RIGHT  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BOTTOM = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TOP    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SPRW   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_SPRH   = 3'd5;

  // Reset values of the configuration registers
  localparam int RST_LEFT   = 0;
  localparam int RST_RIGHT  = 640;
  localparam int RST_BOTTOM = 0;
  localparam int RST_TOP    = 480;
  localparam int RST_SPRW   = 100;
  localparam int RST_SPRH   = 100;

  // Request kinds carried on in_tuser
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_FRAME = 1'b1;

  // Linear congruential generator
  localparam int          LCG_MUL_W = 18;
  localparam logic [17:0] LCG_MUL   = 18'h343fd;
  localparam logic [31:0] LCG_INC   = 32'h0026_9ec3;
  localparam int          DRAW_W    = 15;

  // Serial multiplier walks this many multiplier bits
  localparam int MUL_STEPS = LCG_MUL_W;

  // Square root
  localparam int          ROOT_BITS = 16;
  localparam logic [15:0] SQ_FULL   = 16'hffff;

endpackage

>>> hw/rtl/bouncing_sprite_motion.sv
// Channel | Group                          | Beat contents (low bit first)
// --------+--------------------------------+------------------------------------
// input   | in_tvalid/in_tready/in_tdata/  | tdata: seed_value[31:0]
//         | in_tuser                       | tuser: req_type (0 start, 1 frame)
// result  | out_tvalid/out_tready/out_tdata| tdata: pos_x, pos_y, bounced, zeros
// config  | cfg_we/cfg_addr/cfg_wdata      | one register per write, no wait
//
// One item at a time. A frame without a new velocity runs the edge checks and
// the position step; one with a new velocity also uses the 18-step shift-add
// multiplier (generator and vx^2) and the 16-step two-bit-per-step square root.
// Start item: four generator draws and two position products. Reset (rst_n low,
// synchronous) clears motion state, sets the redraw flag and loads the register
// defaults. A finished result waits in the output register; the next beat is
// taken once the block is back in idle, even while that result is unread.
module bouncing_sprite_motion #(
  parameter int COORD_BITS = bsm_pkg::COORD_BITS_DEF,
  localparam int OUT_W = ((2 * (COORD_BITS + 1) + 1 + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [bsm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [COORD_BITS-1:0]             cfg_wdata,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [31:0]                       in_tdata,   // seed_value
  input  logic                              in_tuser,   // req_type
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [OUT_W-1:0]                  out_tdata   // pos_x, pos_y, bounced
);
  import bsm_pkg::*;

  localparam int CNT_W = $clog2(MUL_STEPS + 1);
  localparam int POS_W = COORD_BITS + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_LCG, S_POSX, S_POSY, S_EDGE_X, S_EDGE_Y,
    S_SQ, S_ROOT, S_VEL, S_OUTF, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    ST_PX, ST_PY, ST_HR, ST_HU, ST_SPEED
  } step_t;

  // configuration
  logic [COORD_BITS-1:0] left_r, right_r, bottom_r, top_r;
  logic [SPRW_BITS-1:0]  sprw_r;
  logic [SPRH_BITS-1:0]  sprh_r;

  // motion state
  logic [31:0] px_r, px_nxt, py_r, py_nxt, vx_r, vx_nxt, vy_r, vy_nxt;
  logic        hr_r, hr_nxt, hu_r, hu_nxt, redraw_r, redraw_nxt;
  logic [31:0] rng_r, rng_nxt;

  // control
  state_t state_r, state_nxt, ret_r, ret_nxt;
  step_t  step_r, step_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0] out_tdata_r, out_tdata_nxt;

  // serial multiplier and root datapath
  logic [31:0]          mcand_r, mcand_nxt, acc_r, acc_nxt;
  logic [LCG_MUL_W-1:0] mplier_r, mplier_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [31:0]          rad_r, rad_nxt;
  logic [ROOT_BITS-1:0] root_r, root_nxt;
  logic [ROOT_BITS:0]   srem_r, srem_nxt;
  logic [15:0]          sx_r, sx_nxt;

  // result
  logic [POS_W-1:0] res_x_r, res_x_nxt, res_y_r, res_y_nxt;
  logic             bnc_r, bnc_nxt;

  // combinational helpers
  logic [31:0]        acc_sum, rng_val, range_x, range_y;
  logic [DRAW_W-1:0]  draw_val;
  logic [16:0]        ix, iy, left17, bot17, hix17, hiy17;
  logic               x_lo, x_hi, y_lo, y_hi;
  logic [ROOT_BITS+2:0] cur, trial;
  logic               ge;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    acc_sum  = acc_r + (mplier_r[0] ? mcand_r : 32'd0);
    rng_val  = acc_r + LCG_INC;
    draw_val = rng_val[30:16];
    range_x  = 32'(right_r) - 32'(left_r) - 32'(sprw_r);
    range_y  = 32'(top_r) - 32'(bottom_r) - 32'(sprh_r);
    ix       = {px_r[31], px_r[31:16]};
    iy       = {py_r[31], py_r[31:16]};
    left17   = 17'(left_r);
    bot17    = 17'(bottom_r);
    hix17    = 17'(right_r) - 17'(sprw_r);
    hiy17    = 17'(top_r) - 17'(sprh_r);
    x_lo     = $signed(ix) < $signed(left17);
    x_hi     = $signed(ix) >= $signed(hix17);
    y_lo     = $signed(iy) < $signed(bot17);
    y_hi     = $signed(iy) >= $signed(hiy17);
    cur      = {srem_r, rad_r[31:30]};
    trial    = {1'b0, root_r, 2'b01};
    ge       = (cur >= trial);
  end

  always_comb begin
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    step_nxt       = step_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    vx_nxt         = vx_r;
    vy_nxt         = vy_r;
    hr_nxt         = hr_r;
    hu_nxt         = hu_r;
    redraw_nxt     = redraw_r;
    rng_nxt        = rng_r;
    mcand_nxt      = mcand_r;
    mplier_nxt     = mplier_r;
    acc_nxt        = acc_r;
    cnt_nxt        = cnt_r;
    rad_nxt        = rad_r;
    root_nxt       = root_r;
    srem_nxt       = srem_r;
    sx_nxt         = sx_r;
    res_x_nxt      = res_x_r;
    res_y_nxt      = res_y_r;
    bnc_nxt        = bnc_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          bnc_nxt = 1'b0;
          if (in_tuser == REQ_START) begin
            rng_nxt    = in_tdata;
            mcand_nxt  = in_tdata;
            mplier_nxt = LCG_MUL;
            acc_nxt    = 32'd0;
            cnt_nxt    = CNT_W'(MUL_STEPS);
            ret_nxt    = S_LCG;
            step_nxt   = ST_PX;
            state_nxt  = S_MUL;
          end else begin
            state_nxt = S_EDGE_X;
          end
        end
      end
      S_MUL: begin
        acc_nxt    = acc_sum;
        mcand_nxt  = {mcand_r[30:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[LCG_MUL_W-1:1]};
        cnt_nxt    = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ret_r;
        end
      end
      S_LCG: begin
        rng_nxt = rng_val;
        acc_nxt = 32'd0;
        cnt_nxt = CNT_W'(MUL_STEPS);
        case (step_r)
          ST_PX: begin
            mcand_nxt  = range_x;
            mplier_nxt = LCG_MUL_W'(draw_val);
            ret_nxt    = S_POSX;
            state_nxt  = S_MUL;
          end
          ST_PY: begin
            mcand_nxt  = range_y;
            mplier_nxt = LCG_MUL_W'(draw_val);
            ret_nxt    = S_POSY;
            state_nxt  = S_MUL;
          end
          ST_HR: begin
            hr_nxt     = draw_val[0];
            mcand_nxt  = rng_val;
            mplier_nxt = LCG_MUL;
            step_nxt   = ST_HU;
            ret_nxt    = S_LCG;
            state_nxt  = S_MUL;
          end
          ST_HU: begin
            hu_nxt     = draw_val[0];
            redraw_nxt = 1'b1;
            res_x_nxt  = px_r[16 +: POS_W];
            res_y_nxt  = py_r[16 +: POS_W];
            state_nxt  = S_DONE;
          end
          default: begin
            // new x speed is 2*draw, below one pixel per frame
            sx_nxt     = {draw_val, 1'b0};
            mcand_nxt  = 32'({draw_val, 1'b0});
            mplier_nxt = LCG_MUL_W'({draw_val, 1'b0});
            ret_nxt    = S_SQ;
            state_nxt  = S_MUL;
          end
        endcase
      end
      S_POSX: begin
        px_nxt     = {16'(left_r), 16'd0} + {acc_r[30:0], 1'b0};
        mcand_nxt  = rng_r;
        mplier_nxt = LCG_MUL;
        acc_nxt    = 32'd0;
        cnt_nxt    = CNT_W'(MUL_STEPS);
        step_nxt   = ST_PY;
        ret_nxt    = S_LCG;
        state_nxt  = S_MUL;
      end
      S_POSY: begin
        py_nxt     = {16'(bottom_r), 16'd0} + {acc_r[30:0], 1'b0};
        mcand_nxt  = rng_r;
        mplier_nxt = LCG_MUL;
        acc_nxt    = 32'd0;
        cnt_nxt    = CNT_W'(MUL_STEPS);
        step_nxt   = ST_HR;
        ret_nxt    = S_LCG;
        state_nxt  = S_MUL;
      end
      S_EDGE_X: begin
        if (x_lo || x_hi) begin
          // mirror about the crossed edge: 2*E - p in 16.16
          px_nxt     = (x_lo ? {left17[14:0], 17'd0} : {hix17[14:0], 17'd0}) - px_r;
          hr_nxt     = x_lo;
          hu_nxt     = (|vy_r) && !vy_r[31];
          redraw_nxt = 1'b1;
        end
        state_nxt = S_EDGE_Y;
      end
      S_EDGE_Y: begin
        if (y_lo || y_hi) begin
          py_nxt     = (y_lo ? {bot17[14:0], 17'd0} : {hiy17[14:0], 17'd0}) - py_r;
          hu_nxt     = y_lo;
          hr_nxt     = (|vx_r) && !vx_r[31];
          redraw_nxt = 1'b1;
        end
        if (redraw_r || y_lo || y_hi) begin
          mcand_nxt  = rng_r;
          mplier_nxt = LCG_MUL;
          acc_nxt    = 32'd0;
          cnt_nxt    = CNT_W'(MUL_STEPS);
          step_nxt   = ST_SPEED;
          ret_nxt    = S_LCG;
          state_nxt  = S_MUL;
        end else begin
          state_nxt = S_OUTF;
        end
      end
      S_SQ: begin
        // root argument is (65535 - vx^2/65536) << 16
        rad_nxt   = {SQ_FULL - acc_r[31:16], 16'd0};
        root_nxt  = '0;
        srem_nxt  = '0;
        cnt_nxt   = CNT_W'(ROOT_BITS);
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        // restoring root, two radicand bits per step
        srem_nxt = ge ? 17'(cur - trial) : cur[ROOT_BITS:0];
        root_nxt = {root_r[ROOT_BITS-2:0], ge};
        rad_nxt  = {rad_r[29:0], 2'b00};
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = S_VEL;
        end
      end
      S_VEL: begin
        vx_nxt     = hr_r ? 32'(sx_r) : 32'd0 - 32'(sx_r);
        vy_nxt     = hu_r ? 32'(root_r) : 32'd0 - 32'(root_r);
        redraw_nxt = 1'b0;
        bnc_nxt    = 1'b1;
        state_nxt  = S_OUTF;
      end
      S_OUTF: begin
        res_x_nxt = px_r[16 +: POS_W];
        res_y_nxt = py_r[16 +: POS_W];
        px_nxt    = px_r + vx_r;
        py_nxt    = py_r + vy_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = OUT_W'({bnc_r, res_y_r, res_x_r});
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ret_r        <= S_IDLE;
      step_r       <= ST_PX;
      out_tvalid_r <= 1'b0;
      px_r         <= '0;
      py_r         <= '0;
      vx_r         <= '0;
      vy_r         <= '0;
      hr_r         <= 1'b0;
      hu_r         <= 1'b0;
      redraw_r     <= 1'b1;
      rng_r        <= '0;
      cnt_r        <= '0;
      left_r       <= COORD_BITS'(RST_LEFT);
      right_r      <= COORD_BITS'(RST_RIGHT);
      bottom_r     <= COORD_BITS'(RST_BOTTOM);
      top_r        <= COORD_BITS'(RST_TOP);
      sprw_r       <= SPRW_BITS'(RST_SPRW);
      sprh_r       <= SPRH_BITS'(RST_SPRH);
    end else begin
      state_r      <= state_nxt;
      ret_r        <= ret_nxt;
      step_r       <= step_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      px_r         <= px_nxt;
      py_r         <= py_nxt;
      vx_r         <= vx_nxt;
      vy_r         <= vy_nxt;
      hr_r         <= hr_nxt;
      hu_r         <= hu_nxt;
      redraw_r     <= redraw_nxt;
      rng_r        <= rng_nxt;
      cnt_r        <= cnt_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_LEFT:   left_r   <= cfg_wdata;
          REG_RIGHT:  right_r  <= cfg_wdata;
          REG_BOTTOM: bottom_r <= cfg_wdata;
          REG_TOP:    top_r    <= cfg_wdata;
          REG_SPRW:   sprw_r   <= cfg_wdata[SPRW_BITS-1:0];
          REG_SPRH:   sprh_r   <= cfg_wdata[SPRH_BITS-1:0];
          default: ;
        endcase
      end
    end
    out_tdata_r <= out_tdata_nxt;
    mcand_r     <= mcand_nxt;
    mplier_r    <= mplier_nxt;
    acc_r       <= acc_nxt;
    rad_r       <= rad_nxt;
    root_r      <= root_nxt;
    srem_r      <= srem_nxt;
    sx_r        <= sx_nxt;
    res_x_r     <= res_x_nxt;
    res_y_r     <= res_y_nxt;
    bnc_r       <= bnc_nxt;
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("block still ready after taking a beat");

  a_vel_needs_redraw: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_VEL |-> redraw_r)
    else $error("velocity drawn without a pending redraw");

  a_redraw_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(redraw_r) |-> $past(state_r) == S_VEL)
    else $error("redraw flag cleared outside velocity update");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && (!out_tvalid_r || out_tready) |=>
      out_tvalid_r && state_r == S_IDLE)
    else $error("finished result not posted");

  a_root_steps: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SQ |=> state_r == S_ROOT && cnt_r == CNT_W'(ROOT_BITS))
    else $error("root iteration count not loaded");

endmodule
